### hdl/conv2d_valid_bias_defines.svh
// Assertion macros used by the block's back-end module.
`ifndef CONV2D_VALID_BIAS_DEFINES_SVH
`define CONV2D_VALID_BIAS_DEFINES_SVH

// Same-cycle implication.
`define CVB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CVB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/cvb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvb_pkg
// Shared types and constants of the bias convolution block.
// ----------------------------------------------------------------------------
package cvb_pkg;

   localparam int DEF_MAX_WIDTH    = 64;
   localparam int DEF_MAX_KERNEL   = 5;
   localparam int DEF_MAX_CHANNELS = 8;
   localparam int DEF_MAX_FILTERS  = 16;
   localparam int MAX_HEIGHT       = 1024;
   localparam int QUEUE_DEPTH      = 4;

   localparam int ROW_W  = 10;
   localparam int SLOT_W = 4;
   localparam int COL_W  = 10;
   localparam int CH_W   = 6;
   localparam int ACC_W  = 48;

   typedef enum logic [2:0] {
      CFG_IMAGE_WIDTH   = 3'd0,
      CFG_IMAGE_HEIGHT  = 3'd1,
      CFG_KERNEL_HEIGHT = 3'd2,
      CFG_KERNEL_WIDTH  = 3'd3,
      CFG_CHANNEL_COUNT = 3'd4,
      CFG_FILTER_COUNT  = 3'd5
   } cfg_index_type;

   typedef enum logic [1:0] {
      KIND_WEIGHT = 2'd0,
      KIND_BIAS   = 2'd1,
      KIND_SAMPLE = 2'd2
   } kind_type;

   // clamped configuration
   typedef struct packed {
      logic [6:0]  w;
      logic [10:0] h;
      logic [2:0]  kh;
      logic [2:0]  kw;
      logic [3:0]  nc;
      logic [4:0]  nf;
   } cfg_type;

   // one queued command, front to back
   typedef struct packed {
      kind_type              kind;
      logic [11:0]           addr;
      logic signed [15:0]    value;
      logic [SLOT_W-1:0]     slot;
      logic [COL_W-1:0]      col;
      logic [CH_W-1:0]       ch;
      logic                  fire;
      logic [SLOT_W-1:0]     base_slot;
      logic [ROW_W-1:0]      r0;
      logic [COL_W-1:0]      c0;
   } cmd_type;

endpackage

### hdl/cvb_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvb channel interfaces
// Request, response and register write channels.
// ----------------------------------------------------------------------------
interface cvb_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [11:0]        address;
   logic signed [15:0] value;
   modport source (output valid, kind, address, value, input ready);
   modport sink (input valid, kind, address, value, output ready);
endinterface

interface cvb_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_value;
   logic [9:0]         out_row;
   logic [5:0]         out_col;
   logic [3:0]         filter_index;
   logic               last;
   modport source (output valid, out_value, out_row, out_col, filter_index, last,
                   input ready);
   modport sink (input valid, out_value, out_row, out_col, filter_index, last,
                 output ready);
endinterface

interface cvb_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [10:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### hdl/cvb_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvb_front
// Accepts words, drops invalid ones, tracks frame position, flags windows.
// ----------------------------------------------------------------------------
module cvb_front
   import cvb_pkg::*;
#(
   parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_FILTERS  = DEF_MAX_FILTERS
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pos_clear,
   cvb_req_if.sink   req_if,
   input  logic      q_full,
   output logic      push,
   output cmd_type   push_cmd
);

   localparam int WEIGHT_DEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;

   logic [ROW_W-1:0]  row_ff, row_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [CH_W-1:0]   ch_ff, ch_in;
   logic              accept, is_sample, keep;
   logic [ROW_W:0]    row_inc;
   logic [COL_W:0]    col_inc;
   logic [SLOT_W-1:0] kh_m1;

   assign req_if.ready = !q_full;
   assign accept       = req_if.valid && req_if.ready;
   assign is_sample    = (req_if.kind == KIND_SAMPLE);
   assign row_inc      = {1'b0, row_ff} + 1'b1;
   assign col_inc      = {1'b0, col_ff} + 1'b1;
   assign kh_m1        = SLOT_W'(cfg.kh) - 1'b1;

   always_comb begin
      keep = 1'b0;
      case (req_if.kind)
         KIND_WEIGHT: keep = (32'(req_if.address) < WEIGHT_DEPTH);
         KIND_BIAS:   keep = (32'(req_if.address) < MAX_FILTERS);
         KIND_SAMPLE: keep = 1'b1;
         default:     keep = 1'b0;
      endcase
   end

   assign push = accept && keep;

   always_comb begin
      push_cmd.kind  = kind_type'(req_if.kind);
      push_cmd.addr  = req_if.address;
      push_cmd.value = req_if.value;
      push_cmd.slot  = slot_ff;
      push_cmd.col   = col_ff;
      push_cmd.ch    = ch_ff;
      push_cmd.fire  = (CH_W'(ch_ff) + 1'b1 == CH_W'(cfg.nc))
                       && (row_inc >= (ROW_W + 1)'(cfg.kh))
                       && (col_inc >= (COL_W + 1)'(cfg.kw));
      push_cmd.base_slot = (slot_ff >= kh_m1) ? slot_ff - kh_m1
                           : slot_ff + SLOT_W'(MAX_KERNEL) - kh_m1;
      push_cmd.r0    = row_ff + 1'b1 - ROW_W'(cfg.kh);
      push_cmd.c0    = col_ff + 1'b1 - COL_W'(cfg.kw);
   end

   // position advance, channel fastest
   always_comb begin
      row_in  = row_ff;
      slot_in = slot_ff;
      col_in  = col_ff;
      ch_in   = ch_ff;
      if (pos_clear) begin
         row_in  = '0;
         slot_in = '0;
         col_in  = '0;
         ch_in   = '0;
      end else if (accept && is_sample) begin
         ch_in = ch_ff + 1'b1;
         if (ch_ff + 1'b1 >= CH_W'(cfg.nc)) begin
            ch_in  = '0;
            col_in = col_ff + 1'b1;
            if (col_inc >= (COL_W + 1)'(cfg.w)) begin
               col_in  = '0;
               row_in  = row_ff + 1'b1;
               slot_in = (slot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0 : slot_ff + 1'b1;
               if (11'(row_inc) >= cfg.h) begin
                  row_in  = '0;
                  slot_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff  <= '0;
         slot_ff <= '0;
         col_ff  <= '0;
         ch_ff   <= '0;
      end else begin
         row_ff  <= row_in;
         slot_ff <= slot_in;
         col_ff  <= col_in;
         ch_ff   <= ch_in;
      end
   end

endmodule

### hdl/cvb_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvb_queue
// Short command queue between front and back.
// ----------------------------------------------------------------------------
module cvb_queue
   import cvb_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   cmd_type          slots_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;

   assign full  = (cnt_ff == (PW + 1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = slots_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### hdl/cvb_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvb_back
// Executes commands: store writes, then per-filter MAC sequencing and output.
// ----------------------------------------------------------------------------
`include "conv2d_valid_bias_defines.svh"

module cvb_back
   import cvb_pkg::*;
#(
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_FILTERS  = DEF_MAX_FILTERS
) (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  cmd_type   head,
   input  logic      empty,
   output logic      pop,
   cvb_rsp_if.source rsp_if
);

   localparam int WEIGHT_DEPTH = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
   localparam int LINE_DEPTH   = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
   localparam int WAW = (WEIGHT_DEPTH > 1) ? $clog2(WEIGHT_DEPTH) : 1;
   localparam int LAW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int FBW = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_type;

   logic signed [15:0] weight_mem [WEIGHT_DEPTH];
   logic signed [15:0] line_mem [LINE_DEPTH];
   logic signed [15:0] bias_mem [MAX_FILTERS];

   state_type          state_ff;
   logic [WAW-1:0]     wi_ff;
   logic [4:0]         f_ff;
   logic [2:0]         r_ff, c_ff;
   logic [3:0]         k_ff;
   logic [SLOT_W-1:0]  slot_ff, base_ff;
   logic [ROW_W-1:0]   r0_ff;
   logic [COL_W-1:0]   c0_ff;
   logic               v1_ff, v2_ff;
   logic signed [15:0] rd_w_ff, rd_x_ff;
   logic signed [31:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic               out_valid_ff;
   logic signed [15:0] out_value_ff;
   logic [9:0]         out_row_ff;
   logic [5:0]         out_col_ff;
   logic [3:0]         out_fil_ff;
   logic               out_last_ff;

   logic               out_free, last_term, last_filter;
   logic [LAW-1:0]     wr_addr, rd_addr;
   logic [COL_W-1:0]   rd_col;
   logic [4:0]         f_next;
   logic signed [ACC_W-9:0] q;
   logic signed [15:0] sat;

   function automatic logic [LAW-1:0] line_addr(input logic [SLOT_W-1:0] s,
                                                input logic [COL_W-1:0] c,
                                                input logic [CH_W-1:0] k);
      return LAW'((int'(s) * MAX_WIDTH + int'(c)) * MAX_CHANNELS + int'(k));
   endfunction

   function automatic logic signed [ACC_W-1:0] bias_init(input logic signed [15:0] b);
      return {{(ACC_W - 24){b[15]}}, b, 8'd0};
   endfunction

   assign pop         = (state_ff == ST_IDLE) && !empty;
   assign out_free    = !out_valid_ff || rsp_if.ready;
   assign last_term   = (k_ff == cfg.nc - 1'b1) && (c_ff == cfg.kw - 1'b1)
                        && (r_ff == cfg.kh - 1'b1);
   assign last_filter = (f_ff == cfg.nf - 1'b1);
   assign f_next      = f_ff + 1'b1;
   assign wr_addr     = line_addr(head.slot, head.col, head.ch);
   assign rd_col      = c0_ff + COL_W'(c_ff);
   assign rd_addr     = line_addr(slot_ff, rd_col, CH_W'(k_ff));
   assign q           = acc_ff[ACC_W-1:8];

   always_comb begin
      if (q > (ACC_W - 8)'(32767)) begin
         sat = 16'sh7fff;
      end else if (q < -(ACC_W - 8)'(32768)) begin
         sat = -16'sh8000;
      end else begin
         sat = q[15:0];
      end
   end

   // stores, registered reads
   always_ff @(posedge clock) begin
      if (pop) begin
         case (head.kind)
            KIND_WEIGHT: weight_mem[WAW'(head.addr)] <= head.value;
            KIND_BIAS:   bias_mem[FBW'(head.addr)] <= head.value;
            KIND_SAMPLE: line_mem[wr_addr] <= head.value;
            default:     ;
         endcase
      end
      rd_w_ff <= weight_mem[wi_ff];
      rd_x_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff   <= (state_ff == ST_RUN);
         v2_ff   <= v1_ff;
         prod_ff <= rd_w_ff * rd_x_ff;
         if (v2_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
         // a word taken while the next one loads is refilled in ST_EMIT
         if (rsp_if.valid && rsp_if.ready && state_ff != ST_EMIT) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (pop && head.kind == KIND_SAMPLE && head.fire) begin
                  base_ff  <= head.base_slot;
                  slot_ff  <= head.base_slot;
                  r0_ff    <= head.r0;
                  c0_ff    <= head.c0;
                  f_ff     <= '0;
                  wi_ff    <= '0;
                  r_ff     <= '0;
                  c_ff     <= '0;
                  k_ff     <= '0;
                  acc_ff   <= bias_init(bias_mem[0]);
                  state_ff <= ST_RUN;
               end
            end
            ST_RUN: begin
               wi_ff <= wi_ff + 1'b1;
               if (k_ff == cfg.nc - 1'b1) begin
                  k_ff <= '0;
                  if (c_ff == cfg.kw - 1'b1) begin
                     c_ff    <= '0;
                     r_ff    <= r_ff + 1'b1;
                     slot_ff <= (slot_ff == SLOT_W'(MAX_KERNEL - 1)) ? '0
                                : slot_ff + 1'b1;
                  end else begin
                     c_ff <= c_ff + 1'b1;
                  end
               end else begin
                  k_ff <= k_ff + 1'b1;
               end
               if (last_term) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!v1_ff && !v2_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_value_ff <= sat;
                  out_row_ff   <= r0_ff[9:0];
                  out_col_ff   <= c0_ff[5:0];
                  out_fil_ff   <= f_ff[3:0];
                  out_last_ff  <= last_filter;
                  if (last_filter) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     f_ff     <= f_next;
                     r_ff     <= '0;
                     c_ff     <= '0;
                     k_ff     <= '0;
                     slot_ff  <= base_ff;
                     acc_ff   <= bias_init(bias_mem[FBW'(f_next)]);
                     state_ff <= ST_RUN;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.out_value    = out_value_ff;
   assign rsp_if.out_row      = out_row_ff;
   assign rsp_if.out_col      = out_col_ff;
   assign rsp_if.filter_index = out_fil_ff;
   assign rsp_if.last         = out_last_ff;

   `CVB_ASSERT_NOW(a_emit_drained, clock, reset, state_ff == ST_EMIT, !v1_ff && !v2_ff, "emit with MAC pipeline busy")
   `CVB_ASSERT_NEXT(a_emit_loads, clock, reset, state_ff == ST_EMIT && out_free, out_valid_ff, "result not loaded")
   `CVB_ASSERT_NOW(a_pop_idle, clock, reset, pop, state_ff == ST_IDLE, "command taken while busy")

endmodule

### hdl/conv2d_valid_bias.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv2d_valid_bias
// Valid multichannel 2D convolution with per-filter bias, Q8.8.
// ----------------------------------------------------------------------------
// Loads and non-closing samples: one word per cycle through a 4-deep queue,
// while the queue is not full. A window-closing sample runs in the back end
// filter by filter: one MAC per cycle over a single weight/line port.
// First result is offered once the MAC pipeline has drained for filter 0.
// Reset is synchronous, active high: position and control clear, registers
// take their default values, weight, bias and line stores stay unwritten.
module conv2d_valid_bias
   import cvb_pkg::*;
#(
   parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
   parameter int MAX_KERNEL   = DEF_MAX_KERNEL,
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   parameter int MAX_FILTERS  = DEF_MAX_FILTERS
) (
   input  logic      clock,
   input  logic      reset,
   cvb_req_if.sink   req_if,
   cvb_rsp_if.source rsp_if,
   cvb_csr_if.sink   csr_if
);

   // raw register bits, clamped on use
   logic [6:0]  width_ff;
   logic [10:0] height_ff;
   logic [2:0]  kh_ff, kw_ff;
   logic [3:0]  nc_ff;
   logic [4:0]  nf_ff;
   cfg_type     cfg;
   logic        csr_wr, pos_clear;
   logic        q_full, q_empty, push, pop;
   cmd_type     push_cmd, head;

   assign csr_if.ready = 1'b1;
   assign csr_wr       = csr_if.valid && csr_if.ready;
   // any known register write restarts the frame
   assign pos_clear    = csr_wr && (csr_if.index <= CFG_FILTER_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 11'd64;
         kh_ff     <= 3'd3;
         kw_ff     <= 3'd3;
         nc_ff     <= 4'd1;
         nf_ff     <= 5'd1;
      end else if (csr_wr) begin
         case (csr_if.index)
            CFG_IMAGE_WIDTH:   width_ff  <= csr_if.data[6:0];
            CFG_IMAGE_HEIGHT:  height_ff <= csr_if.data;
            CFG_KERNEL_HEIGHT: kh_ff     <= csr_if.data[2:0];
            CFG_KERNEL_WIDTH:  kw_ff     <= csr_if.data[2:0];
            CFG_CHANNEL_COUNT: nc_ff     <= csr_if.data[3:0];
            CFG_FILTER_COUNT:  nf_ff     <= csr_if.data[4:0];
            default:           ;
         endcase
      end
   end

   // clamp to 1..max; the clamped value always fits the raw width
   always_comb begin
      cfg.w  = (width_ff == '0) ? 7'd1
               : (32'(width_ff) > MAX_WIDTH) ? 7'(MAX_WIDTH) : width_ff;
      cfg.h  = (height_ff == '0) ? 11'd1
               : (32'(height_ff) > MAX_HEIGHT) ? 11'(MAX_HEIGHT) : height_ff;
      cfg.kh = (kh_ff == '0) ? 3'd1
               : (32'(kh_ff) > MAX_KERNEL) ? 3'(MAX_KERNEL) : kh_ff;
      cfg.kw = (kw_ff == '0) ? 3'd1
               : (32'(kw_ff) > MAX_KERNEL) ? 3'(MAX_KERNEL) : kw_ff;
      cfg.nc = (nc_ff == '0) ? 4'd1
               : (32'(nc_ff) > MAX_CHANNELS) ? 4'(MAX_CHANNELS) : nc_ff;
      cfg.nf = (nf_ff == '0) ? 5'd1
               : (32'(nf_ff) > MAX_FILTERS) ? 5'(MAX_FILTERS) : nf_ff;
   end

   cvb_front #(
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_FILTERS  (MAX_FILTERS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pos_clear (pos_clear),
      .req_if    (req_if),
      .q_full    (q_full),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   cvb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .head     (head),
      .empty    (q_empty)
   );

   cvb_back #(
      .MAX_WIDTH    (MAX_WIDTH),
      .MAX_KERNEL   (MAX_KERNEL),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_FILTERS  (MAX_FILTERS)
   ) u_back (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .head   (head),
      .empty  (q_empty),
      .pop    (pop),
      .rsp_if (rsp_if)
   );

endmodule
